// ----- src/tkre_pkg.sv -----
// ----------------------------------------------------------------------------
// tkre_pkg
// Shared types, constants and helpers of the trimap known-region expansion
// block: pixel layout, configuration bundle, sequencer states, probe codes.
// ----------------------------------------------------------------------------
package tkre_pkg;

  // Default sizes of the pixel store and the search
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 15;

  // Field widths
  localparam int CH_W      = 8;   // one colour or trimap sample
  localparam int COORD_IN_W = 8;  // row / col of an item
  localparam int SIZE_W    = 9;   // image size registers
  // Neighbour coordinates stay below the clamped size (at most 511) and
  // below 255 plus the largest radius, so nine bits hold them.
  localparam int COORD_W   = 9;
  localparam int RADREG_W  = 4;
  localparam int CDIST_W   = 18;  // squared RGB distance, 3 * 255^2 fits
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 18;

  // Trimap codes
  localparam logic [CH_W-1:0] TRI_BG = 8'd0;
  localparam logic [CH_W-1:0] TRI_FG = 8'd255;

  // Register reset values
  localparam logic [RADREG_W-1:0] RST_SEARCH_RADIUS = 4'd10;
  localparam logic [CDIST_W-1:0]  RST_COLOR_THRESH  = 18'd25;
  localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH   = 9'd256;
  localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT  = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_RADIUS = 2'd0,
    REG_COLOR_THRESH  = 2'd1,
    REG_IMAGE_WIDTH   = 2'd2,
    REG_IMAGE_HEIGHT  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // One store entry, blue in the lowest byte
  typedef struct packed {
    logic [CH_W-1:0] trimap;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    action_t               action;
    logic [COORD_IN_W-1:0] row;
    logic [COORD_IN_W-1:0] col;
    pixel_t                pix;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] label;
    logic            still_unknown;
    logic            bad_coordinate;
  } result_t;

  typedef struct packed {
    logic [RADREG_W-1:0] radius;
    logic [CDIST_W-1:0]  threshold;
    logic [SIZE_W-1:0]   width;
    logic [SIZE_W-1:0]   height;
  } cfg_t;

  typedef enum logic [1:0] {
    PR_UNKNOWN,
    PR_FAR,
    PR_MISS,
    PR_MATCH
  } probe_res_t;

  typedef enum logic [1:0] {
    SIDE_LEFT,
    SIDE_RIGHT,
    SIDE_TOP,
    SIDE_BOT
  } probe_side_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELF,
    ST_RING,
    ST_ISSUE,
    ST_EVAL,
    ST_RESULT
  } search_state_t;

  function automatic logic is_known(input logic [CH_W-1:0] t);
    return (t == TRI_BG) || (t == TRI_FG);
  endfunction

endpackage

// ----- src/tkre_pixel_ram.sv -----
// ----------------------------------------------------------------------------
// tkre_pixel_ram
// Single-port pixel store: one write or one read per cycle, registered read
// data, valid in the cycle after the read strobe.
// ----------------------------------------------------------------------------
module tkre_pixel_ram #(
  parameter int DEPTH = tkre_pkg::DEF_MAX_WIDTH * tkre_pkg::DEF_MAX_HEIGHT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  tkre_pkg::pixel_t wdata,
  output tkre_pkg::pixel_t rdata
);

  tkre_pkg::pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- src/tkre_probe_eval.sv -----
// ----------------------------------------------------------------------------
// tkre_probe_eval
// Classifies one neighbour read from the store: unknown, beyond the radius,
// known without colour match, or match.
// ----------------------------------------------------------------------------
module tkre_probe_eval (
  input  tkre_pkg::pixel_t                  self_pix,
  input  tkre_pkg::pixel_t                  nb_pix,
  input  logic                              dist_ok,
  input  logic [tkre_pkg::CDIST_W-1:0]      threshold,
  output tkre_pkg::probe_res_t              result
);

  logic [2*tkre_pkg::CH_W-1:0] sq_b, sq_g, sq_r;
  logic [tkre_pkg::CDIST_W-1:0] cdist;

  function automatic logic [2*tkre_pkg::CH_W-1:0] sq_diff(
    input logic [tkre_pkg::CH_W-1:0] a,
    input logic [tkre_pkg::CH_W-1:0] b
  );
    logic [tkre_pkg::CH_W-1:0] d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  always_comb begin
    sq_b  = sq_diff(self_pix.blue, nb_pix.blue);
    sq_g  = sq_diff(self_pix.green, nb_pix.green);
    sq_r  = sq_diff(self_pix.red, nb_pix.red);
    cdist = tkre_pkg::CDIST_W'(sq_b) + tkre_pkg::CDIST_W'(sq_g)
          + tkre_pkg::CDIST_W'(sq_r);
    if (!tkre_pkg::is_known(nb_pix.trimap)) begin
      result = tkre_pkg::PR_UNKNOWN;
    end else if (!dist_ok) begin
      result = tkre_pkg::PR_FAR;
    end else if (cdist <= threshold) begin
      result = tkre_pkg::PR_MATCH;
    end else begin
      result = tkre_pkg::PR_MISS;
    end
  end

endmodule

// ----- src/tkre_search.sv -----
// ----------------------------------------------------------------------------
// tkre_search
// Item sequencer: writes loads into the store, reads the queried pixel and
// walks the rings of an unknown pixel, one store read per neighbour.
// ----------------------------------------------------------------------------
module tkre_search #(
  parameter int MAX_WIDTH  = tkre_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tkre_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = tkre_pkg::DEF_MAX_RADIUS,
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic               clk,
  input  logic               rst,
  input  tkre_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  tkre_pkg::in_item_t in_item,
  output logic               res_valid,
  input  logic               res_ready,
  output tkre_pkg::result_t  res,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output tkre_pkg::pixel_t   mem_wdata,
  input  tkre_pkg::pixel_t   mem_rdata
);

  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int CW = tkre_pkg::COORD_W;

  tkre_pkg::search_state_t state, state_next;
  tkre_pkg::probe_side_t   side, side_next;
  tkre_pkg::pixel_t        self_q, self_next;
  tkre_pkg::result_t       res_q, res_next;
  tkre_pkg::probe_res_t    pres;

  logic [tkre_pkg::COORD_IN_W-1:0] row_q, row_next, col_q, col_next;
  logic [RW-1:0] k, k_next;
  logic [CW-1:0] l, l_next, k1, k1_next, k2, k2_next, l1, l1_next, l2, l2_next;
  logic          dist_ok, dist_ok_next;

  logic [tkre_pkg::SIZE_W-1:0] w_use, h_use;
  logic [RW-1:0]               rad;
  logic                        in_bad;
  logic [CW-1:0]               pr, pc, addr_r, addr_c, row_w, col_w, k_w, rsum, csum;
  logic [CW-1:0]               dr_full, dc_full;
  logic [RW-1:0]               dr_a, dc_a;
  logic [2*RW-1:0]             sq_r, sq_c, rad2;
  logic [2*RW:0]               d2;
  logic                        scan1_adv, scan2_adv;

  // Effective sizes and radius
  always_comb begin
    w_use  = (32'(cfg.width) > MAX_WIDTH) ? tkre_pkg::SIZE_W'(MAX_WIDTH) : cfg.width;
    h_use  = (32'(cfg.height) > MAX_HEIGHT) ? tkre_pkg::SIZE_W'(MAX_HEIGHT) : cfg.height;
    rad    = (32'(cfg.radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg.radius);
    in_bad = (CW'(in_item.row) >= h_use) || (CW'(in_item.col) >= w_use);
  end

  // Neighbour coordinate and its distance to the queried pixel
  always_comb begin
    case (side)
      tkre_pkg::SIDE_LEFT:  begin pr = l;  pc = l1; end
      tkre_pkg::SIDE_RIGHT: begin pr = l;  pc = l2; end
      tkre_pkg::SIDE_TOP:   begin pr = k1; pc = l;  end
      tkre_pkg::SIDE_BOT:   begin pr = k2; pc = l;  end
      default:              begin pr = l;  pc = l1; end
    endcase
    row_w   = CW'(row_q);
    col_w   = CW'(col_q);
    k_w     = CW'(k);
    dr_full = (pr >= row_w) ? pr - row_w : row_w - pr;
    dc_full = (pc >= col_w) ? pc - col_w : col_w - pc;
    // Every probe lies within the current ring, so offsets fit the radius
    dr_a    = RW'(dr_full);
    dc_a    = RW'(dc_full);
    sq_r    = dr_a * dr_a;
    sq_c    = dc_a * dc_a;
    rad2    = rad * rad;
    d2      = {1'b0, sq_r} + {1'b0, sq_c};
    rsum    = row_w + k_w;
    csum    = col_w + k_w;
  end

  assign mem_addr  = AW'(32'(addr_r) * MAX_WIDTH + 32'(addr_c));
  assign mem_wdata = in_item.pix;
  assign res       = res_q;

  tkre_probe_eval u_eval (
    .self_pix  (self_q),
    .nb_pix    (mem_rdata),
    .dist_ok   (dist_ok),
    .threshold (cfg.threshold),
    .result    (pres)
  );

  always_comb begin
    state_next   = state;
    side_next    = side;
    self_next    = self_q;
    res_next     = res_q;
    row_next     = row_q;
    col_next     = col_q;
    k_next       = k;
    l_next       = l;
    k1_next      = k1;
    k2_next      = k2;
    l1_next      = l1;
    l2_next      = l2;
    dist_ok_next = dist_ok;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    addr_r       = CW'(in_item.row);
    addr_c       = CW'(in_item.col);
    scan1_adv    = 1'b0;
    scan2_adv    = 1'b0;

    case (state)
      tkre_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          row_next = in_item.row;
          col_next = in_item.col;
          if (in_bad) begin
            res_next.label          = '0;
            res_next.still_unknown  = 1'b0;
            res_next.bad_coordinate = 1'b1;
            state_next              = tkre_pkg::ST_RESULT;
          end else if (in_item.action == tkre_pkg::ACT_LOAD) begin
            mem_we = 1'b1;
          end else begin
            mem_re     = 1'b1;
            state_next = tkre_pkg::ST_SELF;
          end
        end
      end

      tkre_pkg::ST_SELF: begin
        self_next               = mem_rdata;
        res_next.label          = mem_rdata.trimap;
        res_next.bad_coordinate = 1'b0;
        // still_unknown doubles as the not-found flag during the search
        res_next.still_unknown  = !tkre_pkg::is_known(mem_rdata.trimap);
        k_next                  = '0;
        state_next = tkre_pkg::is_known(mem_rdata.trimap) ? tkre_pkg::ST_RESULT
                                                          : tkre_pkg::ST_RING;
      end

      tkre_pkg::ST_RING: begin
        k1_next    = (row_w >= k_w) ? row_w - k_w : '0;
        k2_next    = (rsum > h_use - 1'b1) ? h_use - 1'b1 : rsum;
        l1_next    = (col_w >= k_w) ? col_w - k_w : '0;
        l2_next    = (csum > w_use - 1'b1) ? w_use - 1'b1 : csum;
        l_next     = (row_w >= k_w) ? row_w - k_w : '0;
        side_next  = tkre_pkg::SIDE_LEFT;
        state_next = tkre_pkg::ST_ISSUE;
      end

      tkre_pkg::ST_ISSUE: begin
        mem_re       = 1'b1;
        addr_r       = pr;
        addr_c       = pc;
        dist_ok_next = (d2 <= {1'b0, rad2});
        state_next   = tkre_pkg::ST_EVAL;
      end

      tkre_pkg::ST_EVAL: begin
        case (side)
          tkre_pkg::SIDE_LEFT: begin
            if (pres == tkre_pkg::PR_MATCH) begin
              res_next.label         = mem_rdata.trimap;
              res_next.still_unknown = 1'b0;
              state_next             = tkre_pkg::ST_RESULT;
            end else if (pres == tkre_pkg::PR_FAR) begin
              scan1_adv = 1'b1;   // skip the right column of this row
            end else begin
              side_next  = tkre_pkg::SIDE_RIGHT;
              state_next = tkre_pkg::ST_ISSUE;
            end
          end
          tkre_pkg::SIDE_RIGHT: begin
            if (pres == tkre_pkg::PR_MATCH) begin
              res_next.label         = mem_rdata.trimap;
              res_next.still_unknown = 1'b0;
              state_next             = tkre_pkg::ST_RESULT;
            end else begin
              scan1_adv = 1'b1;
            end
          end
          tkre_pkg::SIDE_TOP: begin
            if (pres == tkre_pkg::PR_FAR) begin
              scan2_adv = 1'b1;   // skip the bottom row of this column
            end else begin
              if (pres == tkre_pkg::PR_MATCH) begin
                res_next.label         = mem_rdata.trimap;
                res_next.still_unknown = 1'b0;
              end
              side_next  = tkre_pkg::SIDE_BOT;
              state_next = tkre_pkg::ST_ISSUE;
            end
          end
          tkre_pkg::SIDE_BOT: begin
            // A bottom match overrides a top match in the same column
            if (pres == tkre_pkg::PR_MATCH) begin
              res_next.label         = mem_rdata.trimap;
              res_next.still_unknown = 1'b0;
              state_next             = tkre_pkg::ST_RESULT;
            end else if (!res_q.still_unknown) begin
              state_next = tkre_pkg::ST_RESULT;
            end else begin
              scan2_adv = 1'b1;
            end
          end
          default: begin
            state_next = tkre_pkg::ST_RESULT;
          end
        endcase

        if (scan1_adv) begin
          state_next = tkre_pkg::ST_ISSUE;
          if (l == k2) begin
            l_next    = l1;
            side_next = tkre_pkg::SIDE_TOP;
          end else begin
            l_next    = l + 1'b1;
            side_next = tkre_pkg::SIDE_LEFT;
          end
        end

        if (scan2_adv) begin
          if (l == l2) begin
            if (k == rad) begin
              state_next = tkre_pkg::ST_RESULT;
            end else begin
              k_next     = k + 1'b1;
              state_next = tkre_pkg::ST_RING;
            end
          end else begin
            l_next     = l + 1'b1;
            side_next  = tkre_pkg::SIDE_TOP;
            state_next = tkre_pkg::ST_ISSUE;
          end
        end
      end

      tkre_pkg::ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = tkre_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tkre_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tkre_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    side    <= side_next;
    self_q  <= self_next;
    res_q   <= res_next;
    row_q   <= row_next;
    col_q   <= col_next;
    k       <= k_next;
    l       <= l_next;
    k1      <= k1_next;
    k2      <= k2_next;
    l1      <= l1_next;
    l2      <= l2_next;
    dist_ok <= dist_ok_next;
  end

endmodule

// ----- src/trimap_known_region_expansion_top.sv -----
// ----------------------------------------------------------------------------
// trimap_known_region_expansion_top
// Pixel store with trimap and a ring search that expands the known region
// for one queried pixel at a time.
//
//   Channel   Direction  Beat contents (lowest bit first)
//   s_*       in         tdata: row, col, blue, green, red, trimap_value
//                        tuser: action (0 load, 1 query)
//   m_*       out        tdata: new_label  tuser: still_unknown, bad_coordinate
//   cfg_*     in         write: index 0 radius, 1 threshold, 2 width, 3 height
//
// A load is written as it is taken. A query of a known pixel passes the store read
// and the self state to the result state and the output register, a bad coordinate
// goes straight to the result state. An unknown pixel takes an issue and an evaluate
// step per neighbour read plus a ring step per ring, serialised by the single store port.
// One item is in flight; the next is taken while the result waits in the
// output register. Reset clears control and restores the registers; the
// store keeps whatever was loaded and needs no clearing.
// ----------------------------------------------------------------------------
module trimap_known_region_expansion_top #(
  parameter int MAX_WIDTH  = tkre_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tkre_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = tkre_pkg::DEF_MAX_RADIUS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [47:0]                         s_tdata,  // row, col, blue, green, red, trimap_value
  input  logic [0:0]                          s_tuser,  // action
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,  // new_label
  output logic [1:0]                          m_tuser,  // still_unknown, bad_coordinate
  input  logic                                cfg_we,
  input  logic [tkre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tkre_pkg::CFG_W-1:0]          cfg_data
);

  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

  tkre_pkg::cfg_t     cfg;
  tkre_pkg::in_item_t in_item;
  tkre_pkg::result_t  res;
  tkre_pkg::pixel_t   mem_wdata, mem_rdata;
  logic               res_valid, res_ready;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_addr;

  always_comb begin
    in_item.action     = tkre_pkg::action_t'(s_tuser[0]);
    in_item.row        = s_tdata[7:0];
    in_item.col        = s_tdata[15:8];
    in_item.pix.blue   = s_tdata[23:16];
    in_item.pix.green  = s_tdata[31:24];
    in_item.pix.red    = s_tdata[39:32];
    in_item.pix.trimap = s_tdata[47:40];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius    <= tkre_pkg::RST_SEARCH_RADIUS;
      cfg.threshold <= tkre_pkg::RST_COLOR_THRESH;
      cfg.width     <= tkre_pkg::RST_IMAGE_WIDTH;
      cfg.height    <= tkre_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (tkre_pkg::cfg_reg_t'(cfg_index))
        tkre_pkg::REG_SEARCH_RADIUS: cfg.radius    <= cfg_data[tkre_pkg::RADREG_W-1:0];
        tkre_pkg::REG_COLOR_THRESH:  cfg.threshold <= cfg_data[tkre_pkg::CDIST_W-1:0];
        tkre_pkg::REG_IMAGE_WIDTH:   cfg.width     <= cfg_data[tkre_pkg::SIZE_W-1:0];
        tkre_pkg::REG_IMAGE_HEIGHT:  cfg.height    <= cfg_data[tkre_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tkre_pixel_ram #(
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  tkre_search #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // Output register: take a result when the slot is empty or draining
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= res.label;
      m_tuser <= {res.bad_coordinate, res.still_unknown};
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trimap known-region expansion block. Pixels are
// loaded into small windows with colours drawn near a few base tones, then
// queried; a local ring-search predictor mirrors the pixel store and the
// register settings and checks every result beat in order. Loads and queries
// go out in bursts with random gaps, the result side stalls on its own
// pattern, and the registers are rewritten between idle phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tkre_pkg::*;

  typedef struct packed {
    logic     drain;  // hold this beat until every pending result is back
    in_item_t it;
  } stim_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_TRICKLE} rx_mode_t;

  localparam int IDLE_CYCLES  = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int TARGET_ITEMS = 1520;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  trimap_known_region_expansion_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Register shadow, pixel mirror (updated on accepted beats) and the
  // generator's own view of which entries will have been loaded.
  cfg_t    cfg_sh = '{RST_SEARCH_RADIUS, RST_COLOR_THRESH, RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT};
  pixel_t  pix_mirror [0:65535];
  pixel_t  plan_pix [0:65535];
  bit      loaded_map [0:65535];

  stim_t   item_q[$];
  result_t label_q[$];
  int      err_cnt = 0;
  int      n_items = 0;
  bit      s_beat_taken = 1'b0;
  int      gap_left = 0;
  int      burst_left = 1;
  rx_mode_t rx_mode = RX_OPEN;
  int      rx_left = 0;
  int      rx_tick = 0;

  function automatic bit known_tri(input logic [7:0] t);
    return (t == TRI_BG) || (t == TRI_FG);
  endfunction

  function automatic int used_size(input logic [SIZE_W-1:0] s, input int lim);
    return (int'(s) > lim) ? lim : int'(s);
  endfunction

  function automatic probe_res_t probe_px(input int r0, input int c0, input pixel_t self,
                                          input int r, input int c, input int rad,
                                          inout logic [7:0] label);
    pixel_t q;
    int dr, dc, db, dg, dd, cd;
    q  = pix_mirror[r * DEF_MAX_WIDTH + c];
    if (!known_tri(q.trimap)) return PR_UNKNOWN;
    dr = r - r0;
    dc = c - c0;
    if (dr * dr + dc * dc > rad * rad) return PR_FAR;
    db = int'(self.blue) - int'(q.blue);
    dg = int'(self.green) - int'(q.green);
    dd = int'(self.red) - int'(q.red);
    cd = db * db + dg * dg + dd * dd;
    if (cd <= int'(cfg_sh.threshold)) begin
      label = q.trimap;
      return PR_MATCH;
    end
    return PR_MISS;
  endfunction

  // Returns 1 when the beat produces a result; a load inside the image updates the mirror.
  function automatic bit expand_label(input in_item_t it, output result_t res);
    int w, h, rad, row, col, k1, k2, l1, l2;
    pixel_t self;
    logic [7:0] label;
    bit found;
    probe_res_t pr;
    w   = used_size(cfg_sh.width, DEF_MAX_WIDTH);
    h   = used_size(cfg_sh.height, DEF_MAX_HEIGHT);
    rad = int'(cfg_sh.radius);
    row = int'(it.row);
    col = int'(it.col);
    res = '0;
    if (row >= h || col >= w) begin
      res.bad_coordinate = 1'b1;
      return 1'b1;
    end
    if (it.action == ACT_LOAD) begin
      pix_mirror[row * DEF_MAX_WIDTH + col] = it.pix;
      return 1'b0;
    end
    self  = pix_mirror[row * DEF_MAX_WIDTH + col];
    label = self.trimap;
    found = 1'b0;
    if (known_tri(label)) begin
      res.label = label;
      return 1'b1;
    end
    for (int k = 0; k <= rad && !found; k++) begin
      k1 = (row - k < 0) ? 0 : row - k;
      k2 = (row + k > h - 1) ? h - 1 : row + k;
      l1 = (col - k < 0) ? 0 : col - k;
      l2 = (col + k > w - 1) ? w - 1 : col + k;
      // left then right column; a far left neighbour skips the right one
      for (int l = k1; l <= k2 && !found; l++) begin
        pr = probe_px(row, col, self, l, l1, rad, label);
        if (pr == PR_MATCH) found = 1'b1;
        else if (pr != PR_FAR && probe_px(row, col, self, l, l2, rad, label) == PR_MATCH)
          found = 1'b1;
      end
      // top then bottom row; a bottom match overrides the top one
      for (int l = l1; l <= l2 && !found; l++) begin
        pr = probe_px(row, col, self, k1, l, rad, label);
        if (pr != PR_FAR) begin
          if (pr == PR_MATCH) found = 1'b1;
          if (probe_px(row, col, self, k2, l, rad, label) == PR_MATCH) found = 1'b1;
        end
      end
    end
    res.label         = label;
    res.still_unknown = !found;
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // Result side and input acceptance, sampled at the rising edge
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    in_item_t it;
    result_t  want, got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it.action = action_t'(s_tuser[0]);
        it.row    = s_tdata[7:0];
        it.col    = s_tdata[15:8];
        it.pix    = {s_tdata[47:40], s_tdata[39:32], s_tdata[31:24], s_tdata[23:16]};
        if (expand_label(it, want)) label_q = {label_q, want};
        s_beat_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got.label          = m_tdata;
        got.still_unknown  = m_tuser[0];
        got.bad_coordinate = m_tuser[1];
        if (label_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("unexpected result beat: label %0d unknown %0b bad %0b",
                     got.label, got.still_unknown, got.bad_coordinate);
        end else begin
          want = label_q.pop_front();
          if (got.label !== want.label || got.still_unknown !== want.still_unknown ||
              got.bad_coordinate !== want.bad_coordinate) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("mismatch: expected label %0d unknown %0b bad %0b, got %0d %0b %0b",
                       want.label, want.still_unknown, want.bad_coordinate,
                       got.label, got.still_unknown, got.bad_coordinate);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Sender bursts and receiver stalls, driven at the falling edge
  // ------------------------------------------------------------------------
  always @(negedge clk) begin : drv
    stim_t nx;
    logic  nv;
    logic  nr;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN: nr = 1'b1;
        RX_COIN: nr = $urandom_range(0, 1);
        RX_SLOW: nr = ($urandom_range(0, 7) == 0);
        default: nr = (rx_tick % 3 == 0);
      endcase
      m_tready <= nr;

      if (!s_tvalid || s_beat_taken) begin
        s_beat_taken = 1'b0;
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_q.size() != 0 && (!item_q[0].drain || label_q.size() == 0)) begin
          nx = item_q.pop_front();
          nv = 1'b1;
          s_tdata <= {nx.it.pix.trimap, nx.it.pix.red, nx.it.pix.green, nx.it.pix.blue,
                      nx.it.col, nx.it.row};
          s_tuser <= nx.it.action;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
        s_tvalid <= nv;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  function automatic pixel_t mk_px(input int t, input int r, input int g, input int b);
    return {8'(t), 8'(r), 8'(g), 8'(b)};
  endfunction

  // Colours mostly near a few base tones so the threshold decides
  function automatic pixel_t rand_pixel();
    int sel, t, base_r, base_g, base_b;
    sel = $urandom_range(0, 9);
    t   = (sel < 4) ? TRI_BG : (sel < 7) ? TRI_FG : $urandom_range(1, 254);
    if ($urandom_range(0, 4) == 0)
      return mk_px(t, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       begin base_r = 0;   base_g = 0;   base_b = 0;   end
      1:       begin base_r = 40;  base_g = 40;  base_b = 40;  end
      2:       begin base_r = 200; base_g = 100; base_b = 50;  end
      default: begin base_r = 250; base_g = 250; base_b = 250; end
    endcase
    return mk_px(t, base_r + $urandom_range(0, 4), base_g + $urandom_range(0, 4),
                 base_b + $urandom_range(0, 4));
  endfunction

  function automatic void push_item(input action_t act, input int r, input int c,
                                    input pixel_t p, input bit drain);
    stim_t s;
    int idx;
    s.drain     = drain;
    s.it.action = act;
    s.it.row    = 8'(r);
    s.it.col    = 8'(c);
    s.it.pix    = p;
    item_q = {item_q, s};
    n_items++;
    idx = r * DEF_MAX_WIDTH + c;
    if (act == ACT_LOAD && r < used_size(cfg_sh.height, DEF_MAX_HEIGHT) &&
        c < used_size(cfg_sh.width, DEF_MAX_WIDTH)) begin
      loaded_map[idx] = 1'b1;
      plan_pix[idx]   = p;
    end
  endfunction

  // A query may only touch entries that will have been loaded
  function automatic bit query_ok(input int r, input int c);
    int wu, hu, rad;
    wu  = used_size(cfg_sh.width, DEF_MAX_WIDTH);
    hu  = used_size(cfg_sh.height, DEF_MAX_HEIGHT);
    rad = int'(cfg_sh.radius);
    if (r >= hu || c >= wu) return 1'b1;
    if (!loaded_map[r * DEF_MAX_WIDTH + c]) return 1'b0;
    if (known_tri(plan_pix[r * DEF_MAX_WIDTH + c].trimap)) return 1'b1;
    for (int rr = (r - rad < 0 ? 0 : r - rad); rr <= r + rad && rr < hu; rr++)
      for (int cc = (c - rad < 0 ? 0 : c - rad); cc <= c + rad && cc < wu; cc++)
        if (!loaded_map[rr * DEF_MAX_WIDTH + cc]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic write_regs(input int rad, input int thr, input int w, input int h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SEARCH_RADIUS;
    cfg_data  <= CFG_W'(rad);
    @(negedge clk);
    cfg_index <= REG_COLOR_THRESH;
    cfg_data  <= CFG_W'(thr);
    @(negedge clk);
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= CFG_W'(w);
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= CFG_W'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_sh = '{RADREG_W'(rad), CDIST_W'(thr), SIZE_W'(w), SIZE_W'(h)};
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (item_q.size() != 0 || s_tvalid || label_q.size() != 0);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic gen_phase(input int n);
    int wu, hu, rad, cr, cc, r, c, r0, r1, c0, c1, made;
    bit drain;
    wu   = used_size(cfg_sh.width, DEF_MAX_WIDTH);
    hu   = used_size(cfg_sh.height, DEF_MAX_HEIGHT);
    rad  = int'(cfg_sh.radius);
    made = 0;
    while (made < n) begin
      if (wu == 0 || hu == 0 || $urandom_range(0, 9) == 0) begin
        // noise: any coordinate, full-range pixel
        r = $urandom_range(0, 255);
        c = $urandom_range(0, 255);
        if ($urandom_range(0, 1) == 1 && query_ok(r, c))
          push_item(ACT_QUERY, r, c, pixel_t'($urandom()), 1'b0);
        else
          push_item(ACT_LOAD, r, c, pixel_t'($urandom()), 1'b0);
        made++;
      end else if ($urandom_range(0, 2) == 0) begin
        // revisit already loaded ground
        repeat (4) begin
          r = $urandom_range(0, hu - 1);
          c = $urandom_range(0, wu - 1);
          if (query_ok(r, c)) begin
            push_item(ACT_QUERY, r, c, pixel_t'($urandom()), 1'b0);
            made++;
          end
        end
      end else begin
        // load a window around a centre, then query in it
        cr = $urandom_range(0, hu - 1);
        cc = $urandom_range(0, wu - 1);
        r0 = (cr - rad < 0) ? 0 : cr - rad;
        r1 = (cr + rad > hu - 1) ? hu - 1 : cr + rad;
        c0 = (cc - rad < 0) ? 0 : cc - rad;
        c1 = (cc + rad > wu - 1) ? wu - 1 : cc + rad;
        if ((r1 - r0 + 1) * (c1 - c0 + 1) > 300) begin
          // keep big windows affordable: clip them at a corner
          cr = $urandom_range(0, 1) ? hu - 1 : 0;
          cc = $urandom_range(0, 1) ? wu - 1 : 0;
          r0 = (cr - rad < 0) ? 0 : cr - rad;
          r1 = (cr + rad > hu - 1) ? hu - 1 : cr + rad;
          c0 = (cc - rad < 0) ? 0 : cc - rad;
          c1 = (cc + rad > wu - 1) ? wu - 1 : cc + rad;
        end
        drain = ($urandom_range(0, 19) == 0);
        for (r = r0; r <= r1; r++)
          for (c = c0; c <= c1; c++) begin
            push_item(ACT_LOAD, r, c, rand_pixel(), drain);
            drain = 1'b0;
            made++;
          end
        push_item(ACT_QUERY, cr, cc, pixel_t'($urandom()), 1'b0);
        made++;
        repeat ($urandom_range(0, 6)) begin
          r = cr + $urandom_range(0, 4) - 2;
          c = cc + $urandom_range(0, 4) - 2;
          r = (r < 0) ? 0 : (r > hu - 1) ? hu - 1 : r;
          c = (c < 0) ? 0 : (c > wu - 1) ? wu - 1 : c;
          if (query_ok(r, c)) begin
            push_item(ACT_QUERY, r, c, pixel_t'($urandom()), 1'b0);
            made++;
          end
        end
      end
    end
  endtask

  initial begin : stim
    int ph, rad, thr, w, h;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults, far corners, extreme pixel values
    push_item(ACT_LOAD, 0, 0, mk_px(TRI_BG, 0, 0, 0), 1'b0);
    push_item(ACT_LOAD, 255, 255, mk_px(TRI_FG, 255, 255, 255), 1'b0);
    push_item(ACT_QUERY, 0, 0, '0, 1'b0);
    push_item(ACT_QUERY, 255, 255, '0, 1'b0);
    wait_idle();

    // 3x3 image, radius 1, exact colour match only
    write_regs(1, 0, 3, 3);
    push_item(ACT_LOAD, 0, 0, mk_px(TRI_FG, 10, 20, 30), 1'b0);
    push_item(ACT_LOAD, 0, 1, mk_px(128, 10, 20, 30), 1'b0);
    push_item(ACT_LOAD, 0, 2, mk_px(TRI_BG, 0, 0, 0), 1'b0);
    push_item(ACT_LOAD, 1, 0, mk_px(1, 90, 90, 90), 1'b0);
    push_item(ACT_LOAD, 1, 1, mk_px(254, 200, 200, 200), 1'b0);
    push_item(ACT_LOAD, 1, 2, mk_px(100, 0, 0, 1), 1'b0);
    push_item(ACT_LOAD, 2, 0, mk_px(TRI_FG, 255, 255, 255), 1'b0);
    push_item(ACT_LOAD, 2, 1, mk_px(TRI_BG, 199, 200, 200), 1'b0);
    push_item(ACT_LOAD, 2, 2, mk_px(TRI_BG, 0, 0, 1), 1'b0);
    push_item(ACT_QUERY, 0, 1, '0, 1'b1);   // known neighbour with the same colour
    push_item(ACT_QUERY, 1, 1, '0, 1'b0);   // nothing close enough: stays unknown
    push_item(ACT_QUERY, 1, 2, '0, 1'b0);
    push_item(ACT_QUERY, 1, 0, '0, 1'b0);
    push_item(ACT_LOAD, 3, 0, mk_px(TRI_FG, 1, 2, 3), 1'b0);      // row out of range
    push_item(ACT_QUERY, 0, 3, '0, 1'b0);                          // column out of range
    push_item(ACT_LOAD, 255, 255, mk_px(TRI_BG, 9, 9, 9), 1'b0);  // both out of range
    push_item(ACT_QUERY, 255, 0, '0, 1'b0);

    ph = 0;
    while (n_items < TARGET_ITEMS) begin
      wait_idle();
      case (ph)
        0:       begin rad = 15; thr = 195075; w = 256; h = 256; end
        1:       begin rad = 0;  thr = 0;      w = 1;   h = 1;   end
        2:       begin rad = 3;  thr = 25;     w = 0;   h = 7;   end
        3:       begin rad = 2;  thr = 262143; w = 511; h = 300; end
        4:       begin rad = 15; thr = 100;    w = 256; h = 1;   end
        5:       begin rad = 5;  thr = 0;      w = 9;   h = 0;   end
        default: begin
          rad = $urandom_range(0, 15);
          w   = (rad > 6) ? $urandom_range(1, 14) : $urandom_range(1, 40);
          h   = (rad > 6) ? $urandom_range(1, 14) : $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0:       thr = $urandom_range(0, 60);
            1:       thr = 25;
            2:       thr = $urandom_range(0, 2000);
            default: thr = $urandom_range(0, 195075);
          endcase
        end
      endcase
      write_regs(rad, thr, w, h);
      gen_phase($urandom_range(60, 120));
      ph++;
    end
    wait_idle();

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
